// File: hdl/nearest_scale_alpha_flatten_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor scaler
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SCALE_ALPHA_FLATTEN_TOP_MACROS_SVH
`define NEAREST_SCALE_ALPHA_FLATTEN_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define NSAF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NSAF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NSAF_ASSERT(label, clk, rst, prop, msg)
`define NSAF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hdl/nsaf_pkg.sv
// ----------------------------------------------------------------------------
// nsaf_pkg
// Types and constants shared by the nearest-neighbor scaler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nsaf_pkg;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_REQ  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_SCALE      = 2'd2,
    REG_INV_SCALE  = 2'd3
  } reg_idx_t;

  localparam logic [10:0] OUT_CAP     = 11'd1024;
  localparam logic [7:0]  ALPHA_MAX   = 8'd255;
  localparam logic [28:0] HALF_Q16    = 29'd32768;
  localparam logic [31:0] DIV255_MUL  = 32'd32897;

  typedef struct packed {
    logic       cmd;
    logic [9:0] coord_x;
    logic [9:0] coord_y;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } req_item_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        status;
    logic [10:0] out_width;
    logic [10:0] out_height;
  } rsp_item_t;

  typedef struct packed {
    logic [8:0]  src_width;
    logic [8:0]  src_height;
    logic [18:0] scale_q16;
    logic [24:0] inv_scale_q16;
  } cfg_t;

  // request leaving the mapping pipe toward the blend pipe
  typedef struct packed {
    logic        valid;
    logic        status;
    logic [10:0] out_width;
    logic [10:0] out_height;
  } map_to_blend_t;

endpackage

`default_nettype wire

// File: hdl/nsaf_ram.sv
// ----------------------------------------------------------------------------
// nsaf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nsaf_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 65536,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/nsaf_regs.sv
// ----------------------------------------------------------------------------
// nsaf_regs
// APB register file: source size, scale and inverse scale.
// ----------------------------------------------------------------------------
`default_nettype none

module nsaf_regs import nsaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width     <= 9'd256;
      cfg.src_height    <= 9'd256;
      cfg.scale_q16     <= 19'd65536;
      cfg.inv_scale_q16 <= 25'd65536;
    end else if (wr) begin
      unique case (idx)
        REG_SRC_WIDTH:  cfg.src_width     <= pwdata[8:0];
        REG_SRC_HEIGHT: cfg.src_height    <= pwdata[8:0];
        REG_SCALE:      cfg.scale_q16     <= pwdata[18:0];
        REG_INV_SCALE:  cfg.inv_scale_q16 <= pwdata[24:0];
        default:        cfg.src_width     <= cfg.src_width;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SRC_WIDTH:  prdata = 32'(cfg.src_width);
      REG_SRC_HEIGHT: prdata = 32'(cfg.src_height);
      REG_SCALE:      prdata = 32'(cfg.scale_q16);
      REG_INV_SCALE:  prdata = 32'(cfg.inv_scale_q16);
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/nsaf_map.sv
// ----------------------------------------------------------------------------
// nsaf_map
// Four-stage coordinate pipe: clamp, multiply, map and size, address/status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_scale_alpha_flatten_top_macros.svh"

module nsaf_map import nsaf_pkg::*; #(
  parameter  int MAX_WIDTH  = 256,
  parameter  int MAX_HEIGHT = 256,
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          req_valid,
  output logic          req_stall,
  input  req_item_t     req_item,
  input  logic          down_ready,
  output map_to_blend_t to_blend,
  output logic [AW-1:0] addr,
  output logic          ram_we,
  output logic [31:0]   ram_wdata
);

  localparam logic [12:0]   MW   = 13'(MAX_WIDTH);
  localparam logic [12:0]   MH   = 13'(MAX_HEIGHT);
  localparam logic [AW-1:0] MW_A = AW'(MAX_WIDTH);

  function automatic logic [8:0] clamp_size(logic [8:0] v, logic [12:0] maxv);
    logic [12:0] t;
    t = 13'(v);
    if (t == 13'd0) begin
      t = 13'd1;
    end else if (t > maxv) begin
      t = maxv;
    end
    return t[8:0];
  endfunction

  function automatic logic [10:0] out_size(logic [27:0] p);
    logic [28:0] s;
    logic [12:0] r;
    s = 29'(p) + HALF_Q16;
    r = s[28:16];
    if (r == 13'd0) begin
      return 11'd1;
    end else if (r > 13'(OUT_CAP)) begin
      return OUT_CAP;
    end
    return r[10:0];
  endfunction

  function automatic logic [18:0] map_coord(logic [34:0] p, logic [8:0] w);
    logic [18:0] s;
    logic [18:0] lim;
    s   = p[34:16];
    lim = 19'(w - 9'd1);
    return (s > lim) ? lim : s;
  endfunction

  // stage 1
  logic        v1, s1_cmd, s1_ld_ok;
  logic [9:0]  s1_x, s1_y;
  logic [31:0] s1_pix;
  logic [8:0]  s1_w, s1_h;
  // stage 2
  logic        v2, s2_cmd, s2_ld_ok;
  logic [9:0]  s2_x, s2_y;
  logic [31:0] s2_pix;
  logic [8:0]  s2_w, s2_h;
  logic [34:0] s2_px, s2_py;
  logic [27:0] s2_pw, s2_ph;
  // stage 3
  logic        v3, s3_cmd, s3_ld_ok;
  logic [9:0]  s3_x, s3_y;
  logic [31:0] s3_pix;
  logic [XW-1:0] s3_sx;
  logic [YW-1:0] s3_sy;
  logic [10:0] s3_ow, s3_oh;
  // stage 4
  logic        v4, s4_cmd, s4_ld_ok, s4_status;
  logic [31:0] s4_pix;
  logic [AW-1:0] s4_addr;
  logic [10:0] s4_ow, s4_oh;

  logic        r1, r2, r3, r4;
  logic        ld_ok;
  logic [18:0] sx_sel, sy_sel;

  assign r4 = !v4 || down_ready || (s4_cmd == CMD_LOAD);
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign req_stall = !r1;

  assign ld_ok = (13'(req_item.coord_x) < MW) && (13'(req_item.coord_y) < MH);

  assign sx_sel = (s2_cmd == CMD_LOAD) ? 19'(s2_x) : map_coord(s2_px, s2_w);
  assign sy_sel = (s2_cmd == CMD_LOAD) ? 19'(s2_y) : map_coord(s2_py, s2_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= req_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_cmd   <= req_item.cmd;
      s1_x     <= req_item.coord_x;
      s1_y     <= req_item.coord_y;
      s1_pix   <= {req_item.in_alpha, req_item.in_blue, req_item.in_green, req_item.in_red};
      s1_w     <= clamp_size(cfg.src_width, MW);
      s1_h     <= clamp_size(cfg.src_height, MH);
      s1_ld_ok <= ld_ok;
    end
    if (r2) begin
      s2_cmd   <= s1_cmd;
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_pix   <= s1_pix;
      s2_w     <= s1_w;
      s2_h     <= s1_h;
      s2_ld_ok <= s1_ld_ok;
      s2_px    <= 35'(s1_x) * 35'(cfg.inv_scale_q16);
      s2_py    <= 35'(s1_y) * 35'(cfg.inv_scale_q16);
      s2_pw    <= 28'(s1_w) * 28'(cfg.scale_q16);
      s2_ph    <= 28'(s1_h) * 28'(cfg.scale_q16);
    end
    if (r3) begin
      s3_cmd   <= s2_cmd;
      s3_x     <= s2_x;
      s3_y     <= s2_y;
      s3_pix   <= s2_pix;
      s3_ld_ok <= s2_ld_ok;
      s3_sx    <= sx_sel[XW-1:0];
      s3_sy    <= sy_sel[YW-1:0];
      s3_ow    <= out_size(s2_pw);
      s3_oh    <= out_size(s2_ph);
    end
    if (r4) begin
      s4_cmd    <= s3_cmd;
      s4_pix    <= s3_pix;
      s4_ld_ok  <= s3_ld_ok;
      s4_addr   <= AW'(AW'(s3_sy) * MW_A + AW'(s3_sx));
      s4_status <= (11'(s3_x) >= s3_ow) || (11'(s3_y) >= s3_oh);
      s4_ow     <= s3_ow;
      s4_oh     <= s3_oh;
    end
  end

  assign addr      = s4_addr;
  assign ram_wdata = s4_pix;
  assign ram_we    = v4 && (s4_cmd == CMD_LOAD) && s4_ld_ok;

  assign to_blend.valid      = v4 && (s4_cmd == CMD_REQ);
  assign to_blend.status     = s4_status;
  assign to_blend.out_width  = s4_ow;
  assign to_blend.out_height = s4_oh;

  `NSAF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !v1 && !v2 && !v3 && !v4, "pipe not empty after reset")
  `NSAF_ASSERT(a_no_bubble_hold, clk, rst, v1 && !v2 |=> v2, "stage 1 held over an empty stage 2")
  `NSAF_ASSERT(a_size_range, clk, rst, v3 |-> s3_ow != 11'd0 && s3_ow <= OUT_CAP && s3_oh != 11'd0 && s3_oh <= OUT_CAP, "output size out of range")
  `NSAF_ASSERT(a_col_range, clk, rst, v3 && s3_cmd == CMD_REQ |-> 32'(s3_sx) < 32'(MAX_WIDTH), "mapped column beyond store")

endmodule

`default_nettype wire

// File: hdl/nsaf_blend.sv
// ----------------------------------------------------------------------------
// nsaf_blend
// Three-stage flatten pipe: store read, channel blend over white, divide by 255.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_scale_alpha_flatten_top_macros.svh"

module nsaf_blend import nsaf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  map_to_blend_t from_map,
  output logic          ready,
  input  logic [31:0]   rdata,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rsp_item_t     rsp_item
);

  function automatic logic [15:0] blend_num(logic [7:0] c, logic [7:0] a);
    logic [7:0] inv;
    inv = ALPHA_MAX - a;
    return 16'(16'(c) * 16'(a) + {inv, 8'h00} - 16'(inv));
  endfunction

  function automatic logic [7:0] div255(logic [15:0] n);
    logic [31:0] p;
    p = 32'(n) * DIV255_MUL;
    return p[30:23];
  endfunction

  logic        v5, s5_status;
  logic [10:0] s5_ow, s5_oh;
  logic        v6, s6_status;
  logic [10:0] s6_ow, s6_oh;
  logic [15:0] s6_nr, s6_ng, s6_nb;
  logic        r5, r6, r7;

  assign r7    = !rsp_valid || !rsp_stall;
  assign r6    = !v6 || r7;
  assign r5    = !v5 || r6;
  assign ready = r5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (r5) v5 <= from_map.valid;
      if (r6) v6 <= v5;
      if (r7) rsp_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      s5_status <= from_map.status;
      s5_ow     <= from_map.out_width;
      s5_oh     <= from_map.out_height;
    end
    if (r6) begin
      s6_status <= s5_status;
      s6_ow     <= s5_ow;
      s6_oh     <= s5_oh;
      s6_nr     <= blend_num(rdata[7:0], rdata[31:24]);
      s6_ng     <= blend_num(rdata[15:8], rdata[31:24]);
      s6_nb     <= blend_num(rdata[23:16], rdata[31:24]);
    end
    if (r7) begin
      rsp_item.status     <= s6_status;
      rsp_item.out_width  <= s6_ow;
      rsp_item.out_height <= s6_oh;
      rsp_item.out_red    <= s6_status ? 8'd0 : div255(s6_nr);
      rsp_item.out_green  <= s6_status ? 8'd0 : div255(s6_ng);
      rsp_item.out_blue   <= s6_status ? 8'd0 : div255(s6_nb);
    end
  end

  `NSAF_ASSERT(a_status_black, clk, rst, rsp_valid && rsp_item.status |-> rsp_item.out_red == 8'd0 && rsp_item.out_green == 8'd0 && rsp_item.out_blue == 8'd0, "flagged transaction carries color")
  `NSAF_ASSERT(a_full_backs_up, clk, rst, v5 && v6 && rsp_valid && rsp_stall |-> !ready, "full blend pipe still ready")

endmodule

`default_nettype wire

// File: hdl/nearest_scale_alpha_flatten_top.sv
// ----------------------------------------------------------------------------
// nearest_scale_alpha_flatten_top
// Nearest-neighbor scaler with RGBA flattening onto white, pipelined.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     req_item_t (load or request)
//   rsp      out        rsp_valid/stall     rsp_item_t (one per request)
//   apb      in/out     psel/penable/pready 4 registers at 0x0..0xC
//
// One transaction per cycle sustained while rsp_stall is low; a load gives no result.
// A request's result passes through the 4 mapping stages, the store's
// registered read, the blend stage and the divide stage.
// rsp_stall backs the pipe up stage by stage; empty stages still fill.
// rst empties the pipe and resets the registers; the frame store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_scale_alpha_flatten_top import nsaf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_item_t   req_item,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_item_t   rsp_item
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t          cfg;
  map_to_blend_t to_blend;
  logic          blend_ready;
  logic [AW-1:0] addr;
  logic          ram_we;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  nsaf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nsaf_map #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_map (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_item   (req_item),
    .down_ready (blend_ready),
    .to_blend   (to_blend),
    .addr       (addr),
    .ram_we     (ram_we),
    .ram_wdata  (ram_wdata)
  );

  nsaf_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (blend_ready),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  nsaf_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .from_map  (to_blend),
    .ready     (blend_ready),
    .rdata     (ram_rdata),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

endmodule

`default_nettype wire

// File: tb/tb_nearest_scale_alpha_flatten_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_scale_alpha_flatten_top
// Self-checking bench for the nearest-neighbor scaler. Source pixels are
// loaded and output pixels requested over the valid/stall ports, the size and
// scale registers are reprogrammed over APB between phases, and every result
// is compared field by field with a predictor that tracks the frame store
// and the register settings. Requests only ever read pixels already loaded.
// ----------------------------------------------------------------------------

module tb_nearest_scale_alpha_flatten_top;
  import nsaf_pkg::*;

  localparam int STORE_W     = 256;
  localparam int STORE_H     = 256;
  localparam int STORE_DEPTH = STORE_W * STORE_H;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_SETTLE = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int REPORT_MAX  = 10;
  localparam bit ST_OK       = 1'b0;
  localparam bit ST_OUTSIDE  = 1'b1;

  class scaled_pixel_model;
    cfg_t      cfg;
    bit [31:0] frame_mem [];
    bit        written [];
    rsp_item_t pixels_due [$];
    int        pixel_errors;

    function new();
      frame_mem = new[STORE_DEPTH];
      written = new[STORE_DEPTH];
      cfg.src_width = 9'd256;
      cfg.src_height = 9'd256;
      cfg.scale_q16 = 19'd65536;
      cfg.inv_scale_q16 = 25'd65536;
      pixel_errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_SRC_WIDTH:  cfg.src_width = value[8:0];
        REG_SRC_HEIGHT: cfg.src_height = value[8:0];
        REG_SCALE:      cfg.scale_q16 = value[18:0];
        REG_INV_SCALE:  cfg.inv_scale_q16 = value[24:0];
        default: ;
      endcase
    endfunction

    function int eff_size(logic [8:0] v, int lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : int'(v);
    endfunction

    function int out_dim(int src);
      longint p;
      p = (longint'(src) * cfg.scale_q16 + 32768) >> 16;
      if (p < 1) p = 1;
      if (p > longint'(OUT_CAP)) p = longint'(OUT_CAP);
      return int'(p);
    endfunction

    function int src_coord(int c, int src);
      longint s;
      s = (longint'(c) * cfg.inv_scale_q16) >> 16;
      return (s > src - 1) ? src - 1 : int'(s);
    endfunction

    // store index read by a request, -1 when outside the output image
    function int read_index(int x, int y);
      int w, h;
      w = eff_size(cfg.src_width, STORE_W);
      h = eff_size(cfg.src_height, STORE_H);
      if (x >= out_dim(w) || y >= out_dim(h)) return -1;
      return src_coord(y, h) * STORE_W + src_coord(x, w);
    endfunction

    function logic [7:0] flatten(logic [7:0] c, logic [7:0] a);
      int ci, ai, v;
      ci = c;
      ai = a;
      v = (ci * ai + 255 * (255 - ai)) / 255;
      return v[7:0];
    endfunction

    function void accept_command(req_item_t it);
      int idx;
      rsp_item_t exp;
      bit [31:0] word;
      if (it.cmd == CMD_LOAD) begin
        if (it.coord_x < STORE_W && it.coord_y < STORE_H) begin
          idx = it.coord_y * STORE_W + it.coord_x;
          frame_mem[idx] = {it.in_alpha, it.in_blue, it.in_green, it.in_red};
          written[idx] = 1'b1;
        end
        return;
      end
      exp.out_width = 11'(out_dim(eff_size(cfg.src_width, STORE_W)));
      exp.out_height = 11'(out_dim(eff_size(cfg.src_height, STORE_H)));
      idx = read_index(it.coord_x, it.coord_y);
      if (idx < 0) begin
        exp.out_red = 8'd0;
        exp.out_green = 8'd0;
        exp.out_blue = 8'd0;
        exp.status = ST_OUTSIDE;
      end else begin
        word = frame_mem[idx];
        exp.out_red = flatten(word[7:0], word[31:24]);
        exp.out_green = flatten(word[15:8], word[31:24]);
        exp.out_blue = flatten(word[23:16], word[31:24]);
        exp.status = ST_OK;
      end
      pixels_due.insert(pixels_due.size(), exp);
    endfunction

    function string fmt(rsp_item_t r);
      return $sformatf("rgb %h %h %h status %b size %0dx%0d",
                       r.out_red, r.out_green, r.out_blue, r.status,
                       r.out_width, r.out_height);
    endfunction

    function void check_pixel(rsp_item_t got);
      rsp_item_t exp;
      if (pixels_due.size() == 0) begin
        pixel_errors++;
        if (pixel_errors <= REPORT_MAX) $display("unexpected result: %s", fmt(got));
        return;
      end
      exp = pixels_due.pop_front();
      if (got.out_red !== exp.out_red || got.out_green !== exp.out_green ||
          got.out_blue !== exp.out_blue || got.status !== exp.status ||
          got.out_width !== exp.out_width || got.out_height !== exp.out_height) begin
        pixel_errors++;
        if (pixel_errors <= REPORT_MAX)
          $display("mismatch: expected %s, got %s", fmt(exp), fmt(got));
      end
    endfunction

    function void check_drained();
      if (pixels_due.size() != 0) begin
        pixel_errors += pixels_due.size();
        $display("%0d results never arrived", pixels_due.size());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid;
  logic        req_stall;
  req_item_t   req_item;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_item_t   rsp_item;

  scaled_pixel_model pixel_model;
  int send_idle_pct = 8;
  int stall_pct = 54;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  nearest_scale_alpha_flatten_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check accepted transactions, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) pixel_model.check_pixel(rsp_item);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_item(input req_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pixel_model.accept_command(it);
  endtask

  function automatic logic [31:0] random_rgba();
    logic [7:0] a;
    case ($urandom_range(3))
      0: a = 8'h00;
      1: a = 8'hFF;
      default: a = 8'($urandom);
    endcase
    return {a, 24'($urandom)};
  endfunction

  task automatic load_pixel(input int x, input int y, input logic [31:0] rgba);
    req_item_t it;
    it.cmd = CMD_LOAD;
    it.coord_x = x[9:0];
    it.coord_y = y[9:0];
    it.in_red = rgba[7:0];
    it.in_green = rgba[15:8];
    it.in_blue = rgba[23:16];
    it.in_alpha = rgba[31:24];
    send_item(it);
  endtask

  // loads the source pixel first when the request would read an empty entry
  task automatic request_pixel(input int x, input int y);
    req_item_t it;
    int idx;
    idx = pixel_model.read_index(x, y);
    if (idx >= 0 && !pixel_model.written[idx])
      load_pixel(idx % STORE_W, idx / STORE_W, random_rgba());
    it = req_item_t'({$urandom, $urandom});
    it.cmd = CMD_REQ;
    it.coord_x = x[9:0];
    it.coord_y = y[9:0];
    send_item(it);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    pixel_model.set_reg(idx, value);
  endtask

  task automatic configure(input int w, input int h, input int scale, input int inv);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_SCALE, scale);
    write_reg(REG_INV_SCALE, inv);
  endtask

  task automatic drain_pipe();
    req_valid <= 1'b0;
    while (pixel_model.pixels_due.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic random_traffic(input int count);
    int w, h, ow, oh, pick;
    repeat (count) begin
      w = pixel_model.eff_size(pixel_model.cfg.src_width, STORE_W);
      h = pixel_model.eff_size(pixel_model.cfg.src_height, STORE_H);
      ow = pixel_model.out_dim(w);
      oh = pixel_model.out_dim(h);
      pick = $urandom_range(99);
      if (pick < 28) begin
        load_pixel($urandom_range(w - 1), $urandom_range(h - 1), random_rgba());
      end else if (pick < 33) begin
        load_pixel($urandom_range(STORE_W - 1), $urandom_range(STORE_H - 1),
                   random_rgba());
      end else if (pick < 35) begin
        load_pixel($urandom_range(1023), $urandom_range(1023), random_rgba());
      end else if (pick < 90) begin
        request_pixel($urandom_range(ow - 1), $urandom_range(oh - 1));
      end else begin
        request_pixel($urandom_range(1023), $urandom_range(1023));
      end
    end
  endtask

  initial begin
    int phase, scale, saved_idle;
    pixel_model = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_valid <= 1'b0;
    req_item <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 256x256 source at unit scale
    load_pixel(0, 0, 32'hFF00_0000);
    request_pixel(0, 0);
    load_pixel(255, 255, 32'hFFFF_FFFF);
    load_pixel(255, 0, 32'h800F_55AA);
    load_pixel(0, 255, 32'h0012_3456);
    load_pixel(1023, 1023, 32'hFF11_2233);
    load_pixel(256, 5, 32'hFF44_5566);
    load_pixel(5, 256, 32'hFF77_8899);
    request_pixel(255, 255);
    request_pixel(255, 0);
    request_pixel(0, 255);
    request_pixel(256, 0);
    request_pixel(0, 256);
    request_pixel(1023, 1023);
    load_pixel(10, 10, 32'h40C0_8020);
    request_pixel(10, 10);
    load_pixel(10, 10, 32'hFE01_FE01);
    request_pixel(10, 10);

    for (phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 54;
        stall_pct = 8;
      end
      if (phase == 6) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      if (phase > 0) begin
        drain_pipe();
        case (phase)
          1: configure(1, 1, 0, 16384);
          2: configure(511, 300, 524287, 33554431);
          3: configure(0, 0, 65536, 65536);
          4: configure(17, 23, 131072, 32768);
          5: configure(100, 64, 32768, 131072);
          6: configure(200, 256, 98304, 43691);
          default: begin
            scale = $urandom_range(16384, 196608);
            configure($urandom_range(1, 256), $urandom_range(1, 256), scale,
                      int'(64'h1_0000_0000 / scale) + $urandom_range(3));
          end
        endcase
      end
      random_traffic(110);
      if (phase == 4) begin
        // long result hold-off while requests keep coming
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        hold_asks++;
        repeat (60) request_pixel($urandom_range(33), $urandom_range(45));
        send_idle_pct = saved_idle;
      end
    end

    drain_pipe();
    pixel_model.check_drained();
    if (pixel_model.pixel_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/nsaf_pkg.sv
hdl/nsaf_ram.sv
hdl/nsaf_regs.sv
hdl/nsaf_map.sv
hdl/nsaf_blend.sv
hdl/nearest_scale_alpha_flatten_top.sv
tb/tb_nearest_scale_alpha_flatten_top.sv
